// ----- rtl/mmec_pkg.sv -----
// ----------------------------------------------------------------------------
// mmec_pkg
// shared types and codes for the matrix multiply cell engine
// ----------------------------------------------------------------------------
package mmec_pkg;

    localparam int DIM_W   = 5;
    localparam int REQ_W   = 2;
    localparam int STAT_W  = 2;
    localparam int VALUE_W = 16;
    localparam int SUM_W   = 36;
    localparam int CFG_IDX_W = 3;

    // request codes
    localparam logic [REQ_W-1:0] REQ_WRITE_A = 2'd0;
    localparam logic [REQ_W-1:0] REQ_WRITE_B = 2'd1;
    localparam logic [REQ_W-1:0] REQ_READ    = 2'd2;

    // status codes
    localparam logic [STAT_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_MISMATCH = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_RANGE    = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_A_ROWS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_A_COLS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_B_ROWS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_B_COLS = 3'd3;

    localparam logic signed [31:0] EMPTY_MARK = -32'sd999;

    typedef struct packed {
        logic [REQ_W-1:0]          req_type;
        logic [DIM_W-1:0]          row_index;
        logic [DIM_W-1:0]          col_index;
        logic signed [VALUE_W-1:0] cell_value;
    } req_t;

    typedef struct packed {
        logic [STAT_W-1:0]       status;
        logic signed [SUM_W-1:0] product_value;
    } rsp_t;

    typedef struct packed {
        logic [DIM_W-1:0] a_rows;
        logic [DIM_W-1:0] a_cols;
        logic [DIM_W-1:0] b_rows;
        logic [DIM_W-1:0] b_cols;
    } dims_t;

    // classified request handed from front end to back end
    typedef struct packed {
        logic [REQ_W-1:0]          kind;
        logic [STAT_W-1:0]         status;
        logic [DIM_W-1:0]          row_index;
        logic [DIM_W-1:0]          col_index;
        logic [DIM_W-1:0]          term_count;
        logic signed [VALUE_W-1:0] cell_value;
    } cmd_t;

    typedef struct packed {
        logic clearing;
    } back_stat_t;

endpackage

// ----- rtl/mmec_front.sv -----
// ----------------------------------------------------------------------------
// mmec_front
// accepts requests, checks indexes and dimensions, queues commands
// ----------------------------------------------------------------------------
module mmec_front #(
    parameter int MAX_DIM = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  mmec_pkg::req_t       req,
    input  mmec_pkg::dims_t      dims,
    input  mmec_pkg::back_stat_t stat,
    output logic                 push_valid,
    input  logic                 push_ready,
    output mmec_pkg::cmd_t       push
);

    logic row_cell_ok;
    logic col_cell_ok;
    logic read_range_ok;
    logic keep;
    logic accept_seen_reg;

    assign row_cell_ok = (req.row_index != '0) &&
                         (32'(req.row_index) <= 32'(MAX_DIM));
    assign col_cell_ok = (req.col_index != '0) &&
                         (32'(req.col_index) <= 32'(MAX_DIM));
    assign read_range_ok = row_cell_ok && col_cell_ok &&
                           (req.row_index <= dims.a_rows) &&
                           (req.col_index <= dims.b_cols);

    always_comb
    begin
        keep = 1'b0;
        push = '0;
        push.kind       = req.req_type;
        push.row_index  = req.row_index;
        push.col_index  = req.col_index;
        push.cell_value = req.cell_value;
        push.status     = mmec_pkg::STATUS_OK;
        push.term_count = (32'(dims.a_cols) > 32'(MAX_DIM)) ?
                          mmec_pkg::DIM_W'(MAX_DIM) : dims.a_cols;
        case (req.req_type)
            mmec_pkg::REQ_WRITE_A,
            mmec_pkg::REQ_WRITE_B:
            begin
                keep = row_cell_ok && col_cell_ok;
            end
            mmec_pkg::REQ_READ:
            begin
                keep = 1'b1;
                // dimension check wins over the index check
                if (dims.a_cols != dims.b_rows)
                begin
                    push.status = mmec_pkg::STATUS_MISMATCH;
                end
                else if (!read_range_ok)
                begin
                    push.status = mmec_pkg::STATUS_RANGE;
                end
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign req_ready  = push_ready && !stat.clearing && accept_seen_reg;
    assign push_valid = req_valid && req_ready && keep;

    // holds off requests until this register is set after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accept_seen_reg <= 1'b0;
        end
        else
        begin
            accept_seen_reg <= 1'b1;
        end
    end

endmodule

// ----- rtl/mmec_queue.sv -----
// ----------------------------------------------------------------------------
// mmec_queue
// two-entry command queue between front end and back end
// ----------------------------------------------------------------------------
module mmec_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  mmec_pkg::cmd_t push,
    output logic           pop_valid,
    input  logic           pop_ready,
    output mmec_pkg::cmd_t pop
);

    mmec_pkg::cmd_t entry_reg [2];
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic       do_push;
    logic       do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop        = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push;
        end
    end

endmodule

// ----- rtl/mmec_back.sv -----
// ----------------------------------------------------------------------------
// mmec_back
// cell memories, clearing pass, multiply-accumulate walk, result register
// ----------------------------------------------------------------------------
module mmec_back #(
    parameter int MAX_DIM    = 16,
    parameter int ELEM_WIDTH = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    output logic                 cmd_ready,
    input  mmec_pkg::cmd_t       cmd,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    output mmec_pkg::rsp_t       rsp,
    output mmec_pkg::back_stat_t stat
);

    localparam int CELLS  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int PROD_W = 2 * ELEM_WIDTH;
    localparam int SUM_W  = mmec_pkg::SUM_W;
    localparam int DIM_W  = mmec_pkg::DIM_W;
    localparam logic [ADDR_W-1:0] ROW_STEP  = ADDR_W'(MAX_DIM);
    localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELLS - 1);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_RUN   = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    // each word carries an empty flag above the cell value
    logic [ELEM_WIDTH:0] a_mem [CELLS];
    logic [ELEM_WIDTH:0] b_mem [CELLS];

    logic [1:0]        state_reg, state_next;
    logic [ADDR_W-1:0] clr_reg, clr_next;
    logic [DIM_W-1:0]  rem_reg, rem_next;
    logic              q_vld_reg, t_vld_reg;
    logic              rsp_vld_reg, rsp_vld_next;
    logic              issue;

    logic [ADDR_W-1:0] a_addr_reg, a_addr_next;
    logic [ADDR_W-1:0] b_addr_reg, b_addr_next;
    logic [ELEM_WIDTH:0] a_q_reg, b_q_reg;
    logic signed [SUM_W-1:0] term_reg, term_next;
    logic signed [SUM_W-1:0] acc_reg, acc_next;
    logic [mmec_pkg::STAT_W-1:0] status_reg, status_next;
    mmec_pkg::rsp_t    rsp_reg, rsp_next;

    logic                    mem_we_a, mem_we_b;
    logic [ADDR_W-1:0]       mem_waddr;
    logic [ELEM_WIDTH:0]     mem_wdata;
    logic [ADDR_W-1:0]       row_base, col_base;
    logic signed [ELEM_WIDTH-1:0] elem;
    logic signed [31:0]      elem_ext;
    logic signed [ELEM_WIDTH-1:0] a_val, b_val;
    logic signed [PROD_W-1:0] prod;

    assign row_base = ADDR_W'(cmd.row_index - 5'd1) * ROW_STEP;
    assign col_base = ADDR_W'(cmd.col_index - 5'd1);
    assign elem     = ELEM_WIDTH'($signed(cmd.cell_value));
    assign elem_ext = 32'(elem);

    assign a_val     = $signed(a_q_reg[ELEM_WIDTH-1:0]);
    assign b_val     = $signed(b_q_reg[ELEM_WIDTH-1:0]);
    assign prod      = a_val * b_val;
    assign term_next = (!a_q_reg[ELEM_WIDTH] && !b_q_reg[ELEM_WIDTH]) ?
                       SUM_W'(prod) : '0;

    assign cmd_ready     = (state_reg == ST_IDLE);
    assign stat.clearing = (state_reg == ST_CLEAR);
    assign rsp_valid     = rsp_vld_reg;
    assign rsp           = rsp_reg;

    always_comb
    begin
        state_next   = state_reg;
        clr_next     = clr_reg;
        rem_next     = rem_reg;
        rsp_vld_next = rsp_vld_reg;
        a_addr_next  = a_addr_reg;
        b_addr_next  = b_addr_reg;
        acc_next     = acc_reg;
        status_next  = status_reg;
        rsp_next     = rsp_reg;
        issue        = 1'b0;
        mem_we_a     = 1'b0;
        mem_we_b     = 1'b0;
        mem_waddr    = row_base + col_base;
        mem_wdata    = {(elem_ext == mmec_pkg::EMPTY_MARK), elem};

        if (rsp_vld_reg && rsp_ready)
        begin
            rsp_vld_next = 1'b0;
        end
        if (t_vld_reg)
        begin
            acc_next = acc_reg + term_reg;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                mem_we_a  = 1'b1;
                mem_we_b  = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = {1'b1, {ELEM_WIDTH{1'b0}}};
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == LAST_CELL)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    case (cmd.kind)
                        mmec_pkg::REQ_WRITE_A:
                        begin
                            mem_we_a = 1'b1;
                        end
                        mmec_pkg::REQ_WRITE_B:
                        begin
                            mem_we_b = 1'b1;
                        end
                        mmec_pkg::REQ_READ:
                        begin
                            acc_next    = '0;
                            status_next = cmd.status;
                            a_addr_next = row_base;
                            b_addr_next = col_base;
                            rem_next    = cmd.term_count;
                            state_next  = (cmd.status == mmec_pkg::STATUS_OK) ?
                                          ST_RUN : ST_DONE;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_RUN:
            begin
                if (rem_reg != '0)
                begin
                    issue       = 1'b1;
                    a_addr_next = a_addr_reg + 1'b1;
                    b_addr_next = b_addr_reg + ROW_STEP;
                    rem_next    = rem_reg - 1'b1;
                end
                else if (!q_vld_reg && !t_vld_reg)
                begin
                    // pipeline drained, sum complete
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!rsp_vld_reg || rsp_ready)
                begin
                    rsp_next.status        = status_reg;
                    rsp_next.product_value = acc_reg;
                    rsp_vld_next           = 1'b1;
                    state_next             = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            rem_reg     <= '0;
            q_vld_reg   <= 1'b0;
            t_vld_reg   <= 1'b0;
            rsp_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            rem_reg     <= rem_next;
            q_vld_reg   <= issue;
            t_vld_reg   <= q_vld_reg;
            rsp_vld_reg <= rsp_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_addr_reg <= a_addr_next;
        b_addr_reg <= b_addr_next;
        term_reg   <= term_next;
        acc_reg    <= acc_next;
        status_reg <= status_next;
        rsp_reg    <= rsp_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we_a)
        begin
            a_mem[mem_waddr] <= mem_wdata;
        end
        a_q_reg <= a_mem[a_addr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (mem_we_b)
        begin
            b_mem[mem_waddr] <= mem_wdata;
        end
        b_q_reg <= b_mem[b_addr_reg];
    end

endmodule

// ----- rtl/matrix_multiply_with_empty_cells_unit.sv -----
// ----------------------------------------------------------------------------
// matrix_multiply_with_empty_cells_unit
// integer matrix product cell engine with empty-marked cells
// ----------------------------------------------------------------------------
// After reset the unit sweeps both cell memories to empty, one cell per
// cycle, and takes no request until the sweep ends. The back end writes a
// cell straight from its idle state. A product read walks min(a_cols,
// MAX_DIM) terms through the single multiply-accumulate path, one term per
// cycle from the one read port of each cell memory, through the memory
// read, product and accumulate registers; a read that fails the dimension
// or index check skips the walk and goes on to the result register.
// A two-entry command queue lets requests be taken while a sum runs, and
// the result register holds one finished product while the next is built.
module matrix_multiply_with_empty_cells_unit #(
    parameter int MAX_DIM    = 16,
    parameter int ELEM_WIDTH = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              req_valid,
    output logic                              req_ready,
    input  mmec_pkg::req_t                    req,
    output logic                              rsp_valid,
    input  logic                              rsp_ready,
    output mmec_pkg::rsp_t                    rsp,
    input  logic                              cfg_we,
    input  logic [mmec_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mmec_pkg::DIM_W-1:0]        cfg_data
);

    mmec_pkg::dims_t      dims_reg;
    mmec_pkg::back_stat_t stat;
    mmec_pkg::cmd_t       push;
    mmec_pkg::cmd_t       pop;
    logic                 push_valid, push_ready;
    logic                 pop_valid, pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dims_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                mmec_pkg::CFG_A_ROWS: dims_reg.a_rows <= cfg_data;
                mmec_pkg::CFG_A_COLS: dims_reg.a_cols <= cfg_data;
                mmec_pkg::CFG_B_ROWS: dims_reg.b_rows <= cfg_data;
                mmec_pkg::CFG_B_COLS: dims_reg.b_cols <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    mmec_front #(
        .MAX_DIM (MAX_DIM)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req        (req),
        .dims       (dims_reg),
        .stat       (stat),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push       (push)
    );

    mmec_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push       (push),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop        (pop)
    );

    mmec_back #(
        .MAX_DIM    (MAX_DIM),
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (pop_valid),
        .cmd_ready (pop_ready),
        .cmd       (pop),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .stat      (stat)
    );

endmodule

// ----- rtl/mmec_checker.sv -----
// ----------------------------------------------------------------------------
// mmec_checker
// port-level checks on the matrix multiply cell engine
// ----------------------------------------------------------------------------
module mmec_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           req_ready,
    input logic           rsp_valid,
    input logic           rsp_ready,
    input mmec_pkg::rsp_t rsp
);

    // nothing moves while reset is held
    assert property (@(posedge clk) !rst_n |-> (!req_ready && !rsp_valid))
        else $error("transfer possible during reset");

    // a stalled result keeps its value
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp)))
        else $error("stalled result changed");

    // failed reads carry a zero product
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.status != mmec_pkg::STATUS_OK) |->
        (rsp.product_value == '0))
        else $error("nonzero product with error status");

    // only the three status codes appear
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.status == mmec_pkg::STATUS_OK ||
                       rsp.status == mmec_pkg::STATUS_MISMATCH ||
                       rsp.status == mmec_pkg::STATUS_RANGE))
        else $error("unknown status code");

endmodule

bind matrix_multiply_with_empty_cells_unit mmec_checker u_mmec_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);

// ----- tb/tb_matrix_multiply_with_empty_cells_unit.sv -----
// ----------------------------------------------------------------------------
// tb_matrix_multiply_with_empty_cells_unit
// self-checking bench for the matrix product cell engine
// ----------------------------------------------------------------------------
// A scoreboard keeps its own copy of both cell stores and of the four
// dimension registers, works out the status and dot product for every read
// that the unit takes, and compares each returned result in order. Stimulus
// starts with a short directed list of edge cases and then runs phases of
// random traffic under several matrix shapes, mostly row/column fills
// followed by reads, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module tb_matrix_multiply_with_empty_cells_unit;

    localparam int MAX_DIM     = 16;
    localparam int CYCLE_LIMIT = 500000;
    localparam int SETTLE      = 40;
    localparam int LONG_HOLD   = 300;

    localparam int DIM_W      = mmec_pkg::DIM_W;
    localparam int REQ_W      = mmec_pkg::REQ_W;
    localparam int VALUE_W    = mmec_pkg::VALUE_W;
    localparam int SUM_W      = mmec_pkg::SUM_W;
    localparam int CFG_IDX_W  = mmec_pkg::CFG_IDX_W;
    localparam int CELLS      = MAX_DIM * MAX_DIM;
    localparam int CELL_IDX_W = $clog2(CELLS);
    localparam int REQ_BITS   = $bits(mmec_pkg::req_t);

    localparam logic [REQ_W-1:0]     REQ_UNUSED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

    typedef enum int {FILL_MIXED, FILL_MOST_NEG, FILL_MOST_POS} fill_t;

    class product_scoreboard;
        logic signed [VALUE_W-1:0] cells_a [CELLS];
        logic signed [VALUE_W-1:0] cells_b [CELLS];
        logic [DIM_W-1:0] rows_a;
        logic [DIM_W-1:0] cols_a;
        logic [DIM_W-1:0] rows_b;
        logic [DIM_W-1:0] cols_b;
        mmec_pkg::rsp_t products_due [$];
        int errors;
        int checked;
        int writes_seen;

        function new();
            for (int i = 0; i < CELLS; i++)
            begin
                cells_a[CELL_IDX_W'(i)] = mmec_pkg::EMPTY_MARK[VALUE_W-1:0];
                cells_b[CELL_IDX_W'(i)] = mmec_pkg::EMPTY_MARK[VALUE_W-1:0];
            end
            rows_a = '0;
            cols_a = '0;
            rows_b = '0;
            cols_b = '0;
            errors = 0;
            checked = 0;
            writes_seen = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] data);
            case (idx)
                mmec_pkg::CFG_A_ROWS: rows_a = data;
                mmec_pkg::CFG_A_COLS: cols_a = data;
                mmec_pkg::CFG_B_ROWS: rows_b = data;
                mmec_pkg::CFG_B_COLS: cols_b = data;
                default: ;
            endcase
        endfunction

        function int pending();
            return products_due.size();
        endfunction

        // called for every accepted request
        function void note_request(mmec_pkg::req_t r);
            logic [CELL_IDX_W-1:0] slot;
            int terms;
            int k;
            logic signed [SUM_W-1:0] sum;
            logic signed [VALUE_W-1:0] x;
            logic signed [VALUE_W-1:0] y;
            mmec_pkg::rsp_t want;
            if (r.req_type == mmec_pkg::REQ_WRITE_A || r.req_type == mmec_pkg::REQ_WRITE_B)
            begin
                // writes outside the store are dropped
                if (r.row_index >= 1 && r.row_index <= MAX_DIM &&
                    r.col_index >= 1 && r.col_index <= MAX_DIM)
                begin
                    slot = CELL_IDX_W'((r.row_index - 1) * MAX_DIM + (r.col_index - 1));
                    if (r.req_type == mmec_pkg::REQ_WRITE_A)
                        cells_a[slot] = r.cell_value;
                    else
                        cells_b[slot] = r.cell_value;
                    writes_seen++;
                end
            end
            else if (r.req_type == mmec_pkg::REQ_READ)
            begin
                want.product_value = '0;
                if (cols_a != rows_b)
                    want.status = mmec_pkg::STATUS_MISMATCH;
                else if (r.row_index == 0 || r.row_index > rows_a || r.row_index > MAX_DIM ||
                         r.col_index == 0 || r.col_index > cols_b || r.col_index > MAX_DIM)
                    want.status = mmec_pkg::STATUS_RANGE;
                else
                begin
                    want.status = mmec_pkg::STATUS_OK;
                    terms = (cols_a > MAX_DIM) ? MAX_DIM : cols_a;
                    sum = '0;
                    for (k = 0; k < terms; k++)
                    begin
                        x = cells_a[CELL_IDX_W'((r.row_index - 1) * MAX_DIM + k)];
                        y = cells_b[CELL_IDX_W'(k * MAX_DIM + (r.col_index - 1))];
                        // a term with an empty cell on either side is skipped
                        if (x != mmec_pkg::EMPTY_MARK && y != mmec_pkg::EMPTY_MARK)
                            sum = sum + x * y;
                    end
                    want.product_value = sum;
                end
                products_due.push_back(want);
            end
        endfunction

        function void check_result(mmec_pkg::rsp_t got);
            mmec_pkg::rsp_t want;
            if (products_due.size() == 0)
            begin
                errors++;
                $display("%0t: result with nothing due: status %0d value %0d",
                         $time, got.status, got.product_value);
                return;
            end
            want = products_due.pop_front();
            checked++;
            if (got.status !== want.status)
            begin
                errors++;
                $display("%0t: status mismatch: expected %0d actual %0d",
                         $time, want.status, got.status);
            end
            if (got.product_value !== want.product_value)
            begin
                errors++;
                $display("%0t: product_value mismatch: expected %0d actual %0d",
                         $time, want.product_value, got.product_value);
            end
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b1;
    logic                 req_valid = 1'b0;
    logic                 req_ready;
    mmec_pkg::req_t       req = '0;
    logic                 rsp_valid;
    logic                 rsp_ready = 1'b0;
    mmec_pkg::rsp_t       rsp;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DIM_W-1:0]     cfg_data = '0;

    bit                   no_idle = 1'b0;
    bit                   hold_pending = 1'b0;
    int                   cycle_count = 0;
    int                   requests_sent = 0;
    int                   shapes_used = 0;
    product_scoreboard    products;

    matrix_multiply_with_empty_cells_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("tb_matrix_multiply_with_empty_cells_unit failed");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic int pick_stall();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 50);
    endfunction

    function automatic logic [DIM_W-1:0] pick_index(input logic [DIM_W-1:0] limit);
        logic [DIM_W-1:0] idx;
        if (limit == 0)
            idx = DIM_W'(1);
        else
            idx = DIM_W'($urandom_range(1, (limit > MAX_DIM) ? MAX_DIM : limit));
        return idx;
    endfunction

    function automatic logic signed [VALUE_W-1:0] pick_value(input fill_t fill);
        logic signed [VALUE_W-1:0] v;
        case (fill)
            FILL_MOST_NEG: v = 16'sh8000;
            FILL_MOST_POS: v = 16'sh7fff;
            default:
            begin
                case ($urandom_range(0, 9))
                    0: v = mmec_pkg::EMPTY_MARK[VALUE_W-1:0];
                    1: v = 16'sh8000;
                    2: v = 16'sh7fff;
                    3: v = '0;
                    4, 5: v = VALUE_W'($urandom);
                    default: v = VALUE_W'($urandom_range(0, 200) - 100);
                endcase
            end
        endcase
        return v;
    endfunction

    function automatic mmec_pkg::req_t make_item(input logic [REQ_W-1:0] kind,
                                                 input logic [DIM_W-1:0] row,
                                                 input logic [DIM_W-1:0] col,
                                                 input logic signed [VALUE_W-1:0] value);
        mmec_pkg::req_t item;
        item.req_type   = kind;
        item.row_index  = row;
        item.col_index  = col;
        item.cell_value = value;
        return item;
    endfunction

    // response side: checks every transfer and drives ready with random stalls
    initial
    begin : response_side
        int stall;
        stall = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_valid && rsp_ready)
                products.check_result(rsp);
            if (hold_pending)
            begin
                hold_pending = 1'b0;
                stall = LONG_HOLD;
            end
            else if (stall == 0 && !no_idle)
                stall = pick_stall();
            if (stall > 0)
            begin
                stall--;
                rsp_ready <= 1'b0;
            end
            else
                rsp_ready <= 1'b1;
        end
    end

    // valid stays up across back-to-back transfers
    task automatic send_request(input mmec_pkg::req_t item);
        int gap;
        gap = no_idle ? 0 : pick_gap();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= item;
        do
            @(posedge clk);
        while (!req_ready);
        products.note_request(item);
        requests_sent++;
    endtask

    task automatic wait_idle();
        req_valid <= 1'b0;
        while (products.pending() != 0)
            @(posedge clk);
        // cell writes give no result and may still sit in the command queue
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [DIM_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        products.set_register(idx, data);
    endtask

    task automatic set_dims(input logic [DIM_W-1:0] ar, input logic [DIM_W-1:0] ac,
                            input logic [DIM_W-1:0] br, input logic [DIM_W-1:0] bc);
        wait_idle();
        write_register(CFG_UNUSED, DIM_W'($urandom));
        write_register(mmec_pkg::CFG_A_ROWS, ar);
        write_register(mmec_pkg::CFG_A_COLS, ac);
        write_register(mmec_pkg::CFG_B_ROWS, br);
        write_register(mmec_pkg::CFG_B_COLS, bc);
        cfg_we <= 1'b0;
        shapes_used++;
    endtask

    // fill one row of A and one column of B, then read the product cell and up to two random cells
    task automatic run_dot_sequence();
        logic [DIM_W-1:0] row;
        logic [DIM_W-1:0] col;
        int terms;
        int k;
        int extra;
        fill_t fill;
        row = pick_index(products.rows_a);
        col = pick_index(products.cols_b);
        terms = (products.cols_a > MAX_DIM) ? MAX_DIM : products.cols_a;
        case ($urandom_range(0, 7))
            0: fill = FILL_MOST_NEG;
            1: fill = FILL_MOST_POS;
            default: fill = FILL_MIXED;
        endcase
        for (k = 1; k <= terms; k++)
        begin
            if (fill != FILL_MIXED || $urandom_range(0, 4) != 0)
                send_request(make_item(mmec_pkg::REQ_WRITE_A, row, k[DIM_W-1:0],
                                       pick_value(fill)));
            if (fill != FILL_MIXED || $urandom_range(0, 4) != 0)
                send_request(make_item(mmec_pkg::REQ_WRITE_B, k[DIM_W-1:0], col,
                                       pick_value(fill)));
        end
        send_request(make_item(mmec_pkg::REQ_READ, row, col, VALUE_W'($urandom)));
        extra = $urandom_range(0, 2);
        repeat (extra)
            send_request(make_item(mmec_pkg::REQ_READ, pick_index(products.rows_a),
                                   pick_index(products.cols_b), VALUE_W'($urandom)));
    endtask

    task automatic run_loose_item();
        mmec_pkg::req_t item;
        int pick;
        pick = $urandom_range(0, 19);
        item = make_item(mmec_pkg::REQ_READ, pick_index(products.rows_a),
                         pick_index(products.cols_b), pick_value(FILL_MIXED));
        if (pick < 2)
            item = REQ_BITS'($urandom);
        else if (pick < 7)
        begin
            item.req_type  = mmec_pkg::REQ_WRITE_A;
            item.row_index = pick_index(products.rows_a);
            item.col_index = pick_index(products.cols_a);
        end
        else if (pick < 11)
        begin
            item.req_type  = mmec_pkg::REQ_WRITE_B;
            item.row_index = pick_index(products.rows_b);
            item.col_index = pick_index(products.cols_b);
        end
        else if (pick < 13)
        begin
            item.row_index = DIM_W'($urandom_range(0, 31));
            item.col_index = DIM_W'($urandom_range(0, 31));
        end
        send_request(item);
    endtask

    task automatic run_phase(input logic [DIM_W-1:0] ar, input logic [DIM_W-1:0] ac,
                             input logic [DIM_W-1:0] br, input logic [DIM_W-1:0] bc,
                             input int budget, input bit squeeze);
        int start;
        set_dims(ar, ac, br, bc);
        if (squeeze)
        begin
            // sender keeps offering while the result side holds off
            no_idle = 1'b1;
            hold_pending = 1'b1;
        end
        start = requests_sent;
        while (requests_sent - start < budget)
        begin
            if (products.cols_a == products.rows_b && products.rows_a != 0 &&
                products.cols_b != 0 && $urandom_range(0, 9) < 6)
                run_dot_sequence();
            else
                run_loose_item();
        end
        if (squeeze)
            no_idle = 1'b0;
    endtask

    initial
    begin : stimulus
        int p;
        logic [DIM_W-1:0] ar;
        logic [DIM_W-1:0] ac;
        logic [DIM_W-1:0] br;
        logic [DIM_W-1:0] bc;
        rst_n <= 1'b0;
        products = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // all dimensions still zero after reset
        send_request(make_item(mmec_pkg::REQ_READ, 5'd1, 5'd1, 16'sd0));
        set_dims(5'd16, 5'd16, 5'd16, 5'd16);
        send_request(make_item(mmec_pkg::REQ_WRITE_A, 5'd1, 5'd1, 16'sh7fff));
        send_request(make_item(mmec_pkg::REQ_WRITE_B, 5'd1, 5'd1, 16'sh8000));
        send_request(make_item(mmec_pkg::REQ_READ, 5'd1, 5'd1, 16'sd0));
        // empty cell drops its term
        send_request(make_item(mmec_pkg::REQ_WRITE_A, 5'd1, 5'd2,
                               mmec_pkg::EMPTY_MARK[VALUE_W-1:0]));
        send_request(make_item(mmec_pkg::REQ_WRITE_B, 5'd2, 5'd1, 16'sd5));
        send_request(make_item(mmec_pkg::REQ_READ, 5'd1, 5'd1, 16'sd0));
        send_request(make_item(mmec_pkg::REQ_WRITE_A, 5'd16, 5'd16, 16'sh8000));
        send_request(make_item(mmec_pkg::REQ_WRITE_B, 5'd16, 5'd16, 16'sh8000));
        send_request(make_item(mmec_pkg::REQ_READ, 5'd16, 5'd16, 16'sd0));
        // writes outside the store are dropped
        send_request(make_item(mmec_pkg::REQ_WRITE_A, 5'd0, 5'd1, 16'sd1234));
        send_request(make_item(mmec_pkg::REQ_WRITE_A, 5'd1, 5'd0, 16'sd1234));
        send_request(make_item(mmec_pkg::REQ_WRITE_B, 5'd17, 5'd1, 16'sd1234));
        send_request(make_item(mmec_pkg::REQ_WRITE_B, 5'd1, 5'd31, 16'sd1234));
        send_request(make_item(mmec_pkg::REQ_READ, 5'd1, 5'd1, 16'sd0));
        send_request(make_item(REQ_UNUSED, 5'd5, 5'd5, 16'sd77));
        // read indexes out of range
        send_request(make_item(mmec_pkg::REQ_READ, 5'd0, 5'd1, 16'sd0));
        send_request(make_item(mmec_pkg::REQ_READ, 5'd17, 5'd1, 16'sd0));
        send_request(make_item(mmec_pkg::REQ_READ, 5'd1, 5'd17, 16'sd0));
        send_request(make_item(mmec_pkg::REQ_READ, 5'd31, 5'd31, 16'sd0));
        send_request(make_item(mmec_pkg::REQ_WRITE_B, 5'd1, 5'd1,
                               mmec_pkg::EMPTY_MARK[VALUE_W-1:0]));
        send_request(make_item(mmec_pkg::REQ_READ, 5'd1, 5'd1, 16'sd0));
        // shape mismatch wins over a bad index
        set_dims(5'd16, 5'd15, 5'd16, 5'd16);
        send_request(make_item(mmec_pkg::REQ_READ, 5'd1, 5'd1, 16'sd0));
        send_request(make_item(mmec_pkg::REQ_READ, 5'd0, 5'd31, 16'sd0));

        no_idle = 1'b1;
        run_phase(5'd16, 5'd16, 5'd16, 5'd16, 90, 1'b0);
        no_idle = 1'b0;
        run_phase(5'd3, 5'd5, 5'd5, 5'd2, 60, 1'b0);
        run_phase(5'd1, 5'd1, 5'd1, 5'd1, 40, 1'b0);
        run_phase(5'd2, 5'd0, 5'd0, 5'd2, 30, 1'b0);
        run_phase(5'd31, 5'd31, 5'd31, 5'd31, 70, 1'b0);
        run_phase(5'd16, 5'd16, 5'd16, 5'd16, 90, 1'b1);
        run_phase(5'd4, 5'd7, 5'd6, 5'd4, 40, 1'b0);
        for (p = 0; p < 4; p++)
        begin
            ar = DIM_W'($urandom_range(0, 16));
            ac = DIM_W'($urandom_range(0, 16));
            br = ($urandom_range(0, 3) == 0) ? DIM_W'($urandom_range(0, 16)) : ac;
            bc = DIM_W'($urandom_range(0, 16));
            run_phase(ar, ac, br, bc, 35, 1'b0);
        end
        run_phase(5'd0, 5'd0, 5'd0, 5'd0, 20, 1'b0);

        wait_idle();
        $display("run covered %0d requests, %0d cell writes and %0d product results checked",
                 requests_sent, products.writes_seen, products.checked);
        $display("over %0d matrix shapes: empty, single cell, full, oversized and mismatched",
                 shapes_used);
        if (products.errors == 0 && products.pending() == 0)
            $display("tb_matrix_multiply_with_empty_cells_unit passed");
        else
            $display("tb_matrix_multiply_with_empty_cells_unit failed");
        $finish;
    end

endmodule
